### hdl/gsc_pkg.sv
// Shared types, constants and the month-length table for the GPS-seconds-to-calendar block.
package gsc_pkg;

    // Divide by a constant with a reciprocal multiply: q = (x * RECIP) >> SHIFT, where x is
    // the dividend with the divisor's power-of-two factor already shifted out
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675, rounded up
    localparam logic [13:0] HOUR_RECIP = 14'd9321;      // 2^21 / 225, rounded up
    localparam logic [10:0] MIN_RECIP  = 11'd1093;      // 2^14 / 15, rounded up

    localparam int DAY_SHIFT  = 35;
    localparam int HOUR_SHIFT = 21;
    localparam int MIN_SHIFT  = 14;

    localparam logic [15:0] DAY_OFFSET = 16'd6;
    localparam logic [11:0] BASE_YEAR  = 12'd1980;
    localparam logic [11:0] YEAR_LIMIT = 12'd2059;  // first year that yields an all-zero word

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MINUTE
    } div_sel_t;

    typedef struct packed {
        logic     load;
        div_sel_t sel;
        logic     mul;
        logic     fold;
        logic     year_set;
        logic     year_step;
        logic     month_set;
        logic     month_step;
        logic     out_load;
        logic     out_zero;
    } gsc_cmd_t;

    typedef struct packed {
        logic year_last;
        logic year_fit;
        logic month_fit;
    } gsc_stat_t;

    typedef struct packed {
        logic       in_range;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [11:0] year;
    } gsc_res_t;

    // Days in month 1..12; codes outside that read as 31
    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon) inside
            4'd2:                     len = 5'd28 + {4'b0, leap};
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### hdl/gsc_ctrl.sv
// Sequencer for the divide, year walk and month walk phases, plus output handshake.
module gsc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  gsc_pkg::gsc_stat_t stat,
    output gsc_pkg::gsc_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DMUL,
        ST_DFOLD,
        ST_HMUL,
        ST_HFOLD,
        ST_MMUL,
        ST_MFOLD,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic       oor_reg, oor_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        oor_next      = oor_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DMUL;
                end
            end
            ST_DMUL: begin
                cmd.sel    = gsc_pkg::DIV_DAY;
                cmd.mul    = 1'b1;
                state_next = ST_DFOLD;
            end
            ST_DFOLD: begin
                cmd.sel    = gsc_pkg::DIV_DAY;
                cmd.fold   = 1'b1;
                state_next = ST_HMUL;
            end
            ST_HMUL: begin
                cmd.sel    = gsc_pkg::DIV_HOUR;
                cmd.mul    = 1'b1;
                state_next = ST_HFOLD;
            end
            ST_HFOLD: begin
                cmd.sel    = gsc_pkg::DIV_HOUR;
                cmd.fold   = 1'b1;
                state_next = ST_MMUL;
            end
            ST_MMUL: begin
                cmd.sel    = gsc_pkg::DIV_MINUTE;
                cmd.mul    = 1'b1;
                state_next = ST_MFOLD;
            end
            ST_MFOLD: begin
                cmd.sel      = gsc_pkg::DIV_MINUTE;
                cmd.fold     = 1'b1;
                cmd.year_set = 1'b1;
                state_next   = ST_YEAR;
            end
            ST_YEAR: begin
                if (stat.year_last) begin
                    // walked past the last supported year: send an all-zero word
                    oor_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (stat.year_fit) begin
                    cmd.month_set = 1'b1;
                    oor_next      = 1'b0;
                    state_next    = ST_MONTH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (stat.month_fit) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_DONE: begin
                // hold the finished word until the output register frees up
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_zero  = oor_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            oor_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            oor_reg      <= oor_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

### hdl/gsc_dp.sv
// Datapath: shared reciprocal-multiply divider, year and month walk registers, output register.
module gsc_dp (
    input  logic               aclk,
    input  gsc_pkg::gsc_cmd_t  cmd,
    input  logic [31:0]        in_seconds,
    output gsc_pkg::gsc_stat_t stat,
    output gsc_pkg::gsc_res_t  res
);

    logic [31:0] sec_reg;
    logic [50:0] prod_reg;
    logic [16:0] rem_reg;
    logic [15:0] days_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [11:0] year_reg;
    logic [8:0]  doy_reg;
    logic [3:0]  mon_reg;
    logic        leap_reg;
    gsc_pkg::gsc_res_t res_reg;

    logic [24:0] mul_a;
    logic [25:0] mul_b;
    logic [50:0] mul_p;
    logic [15:0] day_q;
    logic [4:0]  hour_q;
    logic [5:0]  min_q;
    logic [16:0] day_back;
    logic [16:0] hour_back;
    logic [5:0]  min_back;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    // Strip the divisor's power of two, then multiply by the reciprocal of the odd part
    always_comb begin
        case (cmd.sel)
            gsc_pkg::DIV_DAY: begin
                mul_a = sec_reg[31:7];
                mul_b = gsc_pkg::DAY_RECIP;
            end
            gsc_pkg::DIV_HOUR: begin
                mul_a = {12'b0, rem_reg[16:4]};
                mul_b = {12'b0, gsc_pkg::HOUR_RECIP};
            end
            gsc_pkg::DIV_MINUTE: begin
                mul_a = {15'b0, rem_reg[11:2]};
                mul_b = {15'b0, gsc_pkg::MIN_RECIP};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {26'b0, mul_a} * {25'b0, mul_b};

    assign day_q  = prod_reg[gsc_pkg::DAY_SHIFT +: 16];
    assign hour_q = prod_reg[gsc_pkg::HOUR_SHIFT +: 5];
    assign min_q  = prod_reg[gsc_pkg::MIN_SHIFT +: 6];

    // Remainders fit the narrow widths, so the products wrap harmlessly there
    assign day_back  = {1'b0, day_q} * gsc_pkg::SECS_PER_DAY;
    assign hour_back = {12'b0, hour_q} * gsc_pkg::SECS_PER_HOUR;
    assign min_back  = min_q * gsc_pkg::SECS_PER_MIN;

    // Every century inside the walked span is a multiple of 400, so four-year rule suffices
    assign leap = (year_reg[1:0] == 2'b00);
    assign ylen = 9'd365 + {8'b0, leap};
    assign mlen = gsc_pkg::month_days(mon_reg, leap_reg);

    assign stat.year_last = (year_reg >= gsc_pkg::YEAR_LIMIT);
    assign stat.year_fit  = (days_reg <= {7'b0, ylen});
    assign stat.month_fit = (doy_reg <= {4'b0, mlen});

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sec_reg <= in_seconds;
        end
        if (cmd.mul) begin
            prod_reg <= mul_p;
        end
        if (cmd.fold) begin
            case (cmd.sel)
                gsc_pkg::DIV_DAY: begin
                    days_reg <= day_q + gsc_pkg::DAY_OFFSET;
                    rem_reg  <= sec_reg[16:0] - day_back;
                end
                gsc_pkg::DIV_HOUR: begin
                    hour_reg <= hour_q;
                    rem_reg  <= rem_reg - hour_back;
                end
                gsc_pkg::DIV_MINUTE: begin
                    minute_reg <= min_q;
                    second_reg <= rem_reg[5:0] - min_back;
                end
                default: begin
                end
            endcase
        end
        if (cmd.year_set) begin
            year_reg <= gsc_pkg::BASE_YEAR;
        end
        if (cmd.year_step) begin
            days_reg <= days_reg - {7'b0, ylen};
            year_reg <= year_reg + 12'd1;
        end
        if (cmd.month_set) begin
            doy_reg  <= days_reg[8:0];
            mon_reg  <= 4'd1;
            leap_reg <= leap;
        end
        if (cmd.month_step) begin
            doy_reg <= doy_reg - {4'b0, mlen};
            mon_reg <= mon_reg + 4'd1;
        end
        if (cmd.out_load) begin
            if (cmd.out_zero) begin
                res_reg <= '0;
            end else begin
                res_reg.in_range <= 1'b1;
                res_reg.second   <= second_reg;
                res_reg.minute   <= minute_reg;
                res_reg.hour     <= hour_reg;
                res_reg.day      <= doy_reg[4:0];
                res_reg.month    <= mon_reg;
                res_reg.year     <= year_reg;
            end
        end
    end

    assign res = res_reg;

endmodule

### hdl/gps_seconds_to_calendar.sv
// Top level: GPS seconds count to calendar date and time of day.
//
//  channel | dir | tdata (lowest bit up)                              | tuser
//  s_      | in  | gps_seconds[31:0]                                  | -
//  m_      | out | year[11:0] month[15:12] day[20:16] hour[25:21]     | in_range[0]
//          |     | minute[31:26] second[37:32], zero pad [39:38]      |
//
// One item at a time; an item holds the block through the divides, the year walk and the
// month walk; the year walk steps one year a cycle and stops at the limit year.
// Days, hours, minutes and seconds come from three reciprocal multiplies, each then folded.
// A finished word sits in the output register while the next word is taken and worked on;
// an unread word stalls the block in its last state until the output register frees up.
// Reset (aresetn low, synchronous) empties the output register and returns to idle.
module gps_seconds_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // gps_seconds[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // year, month, day, hour, minute, second, pad
    output logic [0:0]  m_tuser    // in_range
);

    gsc_pkg::gsc_cmd_t  cmd;
    gsc_pkg::gsc_stat_t stat;
    gsc_pkg::gsc_res_t  res;

    gsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gsc_dp u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .in_seconds (s_tdata),
        .stat       (stat),
        .res        (res)
    );

    assign m_tdata = {2'b00, res.second, res.minute, res.hour, res.day, res.month, res.year};
    assign m_tuser = res.in_range;

    // Out-of-range words carry nothing
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("out-of-range word not cleared");

    // An in-range word is a real date and time
    a_date_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[15:12] != 4'd0 && m_tdata[15:12] <= 4'd12 && m_tdata[20:16] != 5'd0 &&
            m_tdata[25:21] <= 5'd23 && m_tdata[31:26] <= 6'd59 && m_tdata[37:32] <= 6'd59)
        else $error("calendar fields out of range");

    // Taking a word starts work: no second word the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // A new word only appears once the previous one has gone
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("pending word overwritten");

endmodule

### sim/gsc_date_check.sv
// Calendar helpers, plus a checker that predicts each result word and compares it.
`timescale 1ns / 100ps

package gsc_tb_pkg;

    localparam int SECS_DAY        = 86400;
    localparam int FIRST_YEAR      = 1980;
    localparam int ZERO_YEAR       = 2060;
    localparam int EPOCH_DAY_SHIFT = 6;

    function automatic int year_len(input int yr);
        if (yr % 4 != 0 || (yr % 100 == 0 && yr % 400 != 0)) begin
            return 365;
        end
        return 366;
    endfunction

    function automatic int days_in_month(input int mo, input int yr);
        case (mo)
            2:             return year_len(yr) - 337;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Seconds since the GPS epoch for a calendar date; negative before the epoch
    function automatic longint gps_at(input int yr, input int mo, input int dd,
                                      input int hh, input int mi, input int ss);
        longint ord;
        ord = dd;
        for (int y = FIRST_YEAR; y < yr; y++) ord += year_len(y);
        for (int m = 1; m < mo; m++) ord += days_in_month(m, yr);
        return (ord - EPOCH_DAY_SHIFT) * longint'(SECS_DAY) + hh * 3600 + mi * 60 + ss;
    endfunction

endpackage

module gsc_date_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // gps_seconds[31:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // year, month, day, hour, minute, second, pad
    input  logic [0:0]  m_tuser,   // in_range
    output int          fail_count,
    output int          words_due
);

    typedef struct {
        logic [31:0]       secs;
        gsc_pkg::gsc_res_t date;
    } due_date_t;

    due_date_t due_dates[$];
    int        errors  = 0;
    int        pending = 0;

    assign fail_count = errors;
    assign words_due  = pending;

    function automatic gsc_pkg::gsc_res_t predict_calendar(input logic [31:0] secs);
        int                days;
        int                yr;
        int                ylen;
        int                mo;
        gsc_pkg::gsc_res_t date;
        date = '0;
        days = int'(secs / 32'(gsc_tb_pkg::SECS_DAY)) + gsc_tb_pkg::EPOCH_DAY_SHIFT;
        yr   = gsc_tb_pkg::FIRST_YEAR;
        ylen = 365;
        while (days > 0 && yr <= gsc_tb_pkg::ZERO_YEAR) begin
            ylen = gsc_tb_pkg::year_len(yr);
            days -= ylen;
            yr++;
        end
        // anything from 2059 onwards comes back as an all-zero word
        if (yr >= gsc_tb_pkg::ZERO_YEAR) begin
            return date;
        end
        // step back into the year the walk overshot
        days += ylen;
        yr--;
        mo = 1;
        while (days > 0 && mo < 13) begin
            days -= gsc_tb_pkg::days_in_month(mo, yr);
            mo++;
        end
        mo--;
        days += gsc_tb_pkg::days_in_month(mo, yr);
        date.year     = 12'(yr);
        date.month    = 4'(mo);
        date.day      = 5'(days);
        date.hour     = 5'((secs % 32'd86400) / 32'd3600);
        date.minute   = 6'((secs % 32'd3600) / 32'd60);
        date.second   = 6'(secs % 32'd60);
        date.in_range = 1'b1;
        return date;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] secs,
                                   input int got, input int want);
        $display("%0t MISMATCH %s for seconds %0d: got %0d, expected %0d",
                 $realtime, what, secs, got, want);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [31:0] secs,
                               input int got, input int want);
        if (got != want) begin
            report_mismatch(what, secs, got, want);
        end
    endtask

    always @(posedge aclk) begin
        due_date_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_dates.size() == 0) begin
                    report_mismatch("word with nothing outstanding", 32'd0,
                                    int'(m_tdata[31:0]), 0);
                end else begin
                    want = due_dates.pop_front();
                    check_field("year", want.secs, int'(m_tdata[11:0]),
                                int'(want.date.year));
                    check_field("month", want.secs, int'(m_tdata[15:12]),
                                int'(want.date.month));
                    check_field("day", want.secs, int'(m_tdata[20:16]),
                                int'(want.date.day));
                    check_field("hour", want.secs, int'(m_tdata[25:21]),
                                int'(want.date.hour));
                    check_field("minute", want.secs, int'(m_tdata[31:26]),
                                int'(want.date.minute));
                    check_field("second", want.secs, int'(m_tdata[37:32]),
                                int'(want.date.second));
                    check_field("pad", want.secs, int'(m_tdata[39:38]), 0);
                    check_field("in_range", want.secs, int'(m_tuser[0]),
                                int'(want.date.in_range));
                end
            end
            if (s_tvalid && s_tready) begin
                want.secs = s_tdata;
                want.date = predict_calendar(s_tdata);
                due_dates.push_back(want);
            end
            pending = due_dates.size();
        end
    end

endmodule

### sim/testbench.sv
// Top of the testbench: clock, reset, stimulus and verdict for the calendar converter.
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_WORDS = 1250;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;

    int          send_idle_pct = 37;
    int          recv_idle_pct = 60;
    int          fail_count;
    int          words_due;
    logic [31:0] last_in_range;
    logic [31:0] first_zero;

    gps_seconds_to_calendar DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gsc_date_check u_date_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    function automatic logic [31:0] to_word(input longint v);
        if (v < 0) begin
            return 32'd0;
        end
        if (v > longint'(32'hFFFF_FFFF)) begin
            return 32'hFFFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] pick_seconds();
        int     kind;
        int     yr;
        int     mo;
        int     dd;
        longint base;
        kind = $urandom_range(99, 0);
        if (kind < 45) begin
            return $urandom_range(last_in_range, 0);
        end
        if (kind < 75) begin
            // land on or beside the first or last day of a month
            yr   = $urandom_range(2059, gsc_tb_pkg::FIRST_YEAR);
            mo   = $urandom_range(12, 1);
            dd   = $urandom_range(1, 0) ? 1 : gsc_tb_pkg::days_in_month(mo, yr);
            base = gsc_tb_pkg::gps_at(yr, mo, dd, 0, 0, 0);
            case ($urandom_range(3, 0))
                0:       base += $urandom_range(3, 0);
                1:       base += gsc_tb_pkg::SECS_DAY - 1 - $urandom_range(3, 0);
                2:       base += $urandom_range(gsc_tb_pkg::SECS_DAY - 1, 0);
                default: base -= $urandom_range(3, 1);
            endcase
            return to_word(base);
        end
        if (kind < 88) begin
            return $urandom;
        end
        return $urandom_range(32'hFFFF_FFFF, first_zero);
    endfunction

    task automatic send_word(input logic [31:0] secs);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_date(input int yr, input int mo, input int dd,
                             input int hh, input int mi, input int ss);
        send_word(to_word(gsc_tb_pkg::gps_at(yr, mo, dd, hh, mi, ss)));
    endtask

    initial begin
        last_in_range = to_word(gsc_tb_pkg::gps_at(2058, 12, 31, 23, 59, 59));
        first_zero    = last_in_range + 32'd1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // field extremes and calendar corners
        send_word(32'd0);
        send_word(32'hFFFF_FFFF);
        send_word(32'hAAAA_AAAA);
        send_word(32'h5555_5555);
        send_word(32'd86399);
        send_word(32'd86400);
        send_date(1980, 1, 31, 23, 59, 59);
        send_date(1980, 2, 1, 0, 0, 0);
        send_date(1980, 2, 29, 23, 59, 59);
        send_date(1980, 3, 1, 0, 0, 0);
        send_date(1980, 12, 31, 23, 59, 59);
        send_date(1981, 1, 1, 0, 0, 0);
        send_date(1981, 2, 28, 23, 59, 59);
        send_date(1981, 3, 1, 0, 0, 0);
        send_date(1981, 12, 31, 12, 0, 0);
        send_date(2000, 2, 29, 12, 34, 56);
        send_date(2000, 12, 31, 23, 59, 59);
        send_date(2020, 4, 30, 7, 8, 9);
        send_date(2020, 11, 30, 23, 0, 59);
        send_word(last_in_range);
        send_word(first_zero);
        send_date(2058, 1, 1, 0, 0, 0);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            // swap the idling sides after a third, drop idling after two thirds
            if (i == RANDOM_WORDS / 3) begin
                send_idle_pct = 60;
                recv_idle_pct = 37;
            end else if (i == 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_word(pick_seconds());
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (words_due != 0) @(posedge aclk);
        repeat (140) @(posedge aclk);

        if (fail_count == 0 && words_due == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
